// ===== hw/rtl/alie_pkg.sv =====
// Shared constants, codes and command/status types of the ordered list engine.
`timescale 1ns / 1ps

package alie_pkg;

   // Default store depth in elements.
   localparam int DEPTH_DEFAULT = 64;

   // Fixed field widths.
   localparam int OP_W   = 3;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_RESIZE = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // What a store read is for: moving an element up, moving it down, or dumping it.
   typedef enum logic [1:0] {
      RK_UP,
      RK_DOWN,
      RK_DUMP
   } rd_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load;          // capture the request fields
      logic                 set_pos_count; // append: position becomes the count
      logic                 ptr_load_top;  // pointer to count - 1
      logic                 ptr_load_pos1; // pointer to position + 1
      logic                 ptr_load_zero; // pointer to entry zero
      logic                 rd_en;         // read the store at the pointer, step it
      rd_kind_type          rd_kind;
      logic                 put;           // write the new value, count up
      logic                 cnt_dec;       // count down by one
      logic                 cnt_trunc;     // resize truncation
      logic                 emit;          // emit a single-word result
      logic [STAT_W-1:0]    emit_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_append;
      logic op_insert;
      logic op_remove;
      logic op_resize;
      logic op_dump;
      logic pos_gt_count;
      logic pos_ge_count;
      logic pos_eq_count;
      logic pos_last;
      logic full;
      logic empty;
      logic ptr_at_pos;
      logic ptr_at_end;
   } stat_type;

endpackage

// ===== hw/rtl/alie_datapath.sv =====
// Datapath of the ordered list engine: element store, count, walk pointer and result register.
`timescale 1ns / 1ps

module alie_datapath #(
   parameter int DEPTH = alie_pkg::DEPTH_DEFAULT,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  alie_pkg::cmd_type              cmd,
   output alie_pkg::stat_type             stat,
   input  logic [alie_pkg::OP_W-1:0]      req_operation,
   input  logic [CW-1:0]                  req_position,
   input  logic signed [alie_pkg::VAL_W-1:0] req_new_value,
   input  logic [CW-1:0]                  req_new_length,
   output logic                           rsp_strobe,
   output logic [alie_pkg::STAT_W-1:0]    rsp_status,
   output logic [CW-1:0]                  rsp_count_after,
   output logic                           rsp_has_element,
   output logic signed [alie_pkg::VAL_W-1:0] rsp_element_out,
   output logic                           rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [alie_pkg::VAL_W-1:0] element_store_ff [DEPTH];

   logic [alie_pkg::OP_W-1:0]   op_ff, op_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic [alie_pkg::VAL_W-1:0]  val_ff, val_in;
   logic [CW-1:0]               len_ff, len_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [AW-1:0]               ptr_ff, ptr_in;

   // Read pipe: data read last cycle and where it goes.
   logic                        pv_ff, pv_in;
   logic                        pdump_ff, pdump_in;
   logic                        plast_ff, plast_in;
   logic [AW-1:0]               wa_ff, wa_in;
   logic [alie_pkg::VAL_W-1:0]  rdata_ff;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [alie_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0]               rsp_count_ff, rsp_count_in;
   logic                        rsp_has_ff, rsp_has_in;
   logic [alie_pkg::VAL_W-1:0]  rsp_elem_ff, rsp_elem_in;
   logic                        rsp_last_ff, rsp_last_in;

   always_comb begin
      stat.op_append    = (op_ff == alie_pkg::OP_APPEND);
      stat.op_insert    = (op_ff == alie_pkg::OP_INSERT);
      stat.op_remove    = (op_ff == alie_pkg::OP_REMOVE);
      stat.op_resize    = (op_ff == alie_pkg::OP_RESIZE);
      stat.op_dump      = (op_ff == alie_pkg::OP_DUMP);
      stat.pos_gt_count = (pos_ff > count_ff);
      stat.pos_ge_count = (pos_ff >= count_ff);
      stat.pos_eq_count = (pos_ff == count_ff);
      stat.pos_last     = (((CW+1)'(pos_ff) + (CW+1)'(1)) == (CW+1)'(count_ff));
      stat.full         = (count_ff >= DEPTH_C);
      stat.empty        = (count_ff == '0);
      stat.ptr_at_pos   = (CW'(ptr_ff) == pos_ff);
      stat.ptr_at_end   = (((CW+1)'(ptr_ff) + (CW+1)'(1)) == (CW+1)'(count_ff));
   end

   always_comb begin
      op_in  = op_ff;
      pos_in = pos_ff;
      val_in = val_ff;
      len_in = len_ff;
      if (cmd.load) begin
         op_in  = req_operation;
         pos_in = req_position;
         val_in = req_new_value;
         len_in = req_new_length;
      end else if (cmd.set_pos_count) begin
         pos_in = count_ff;
      end

      count_in = count_ff;
      if (cmd.put) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.cnt_trunc && (len_ff < count_ff)) begin
         count_in = len_ff;
      end

      ptr_in = ptr_ff;
      if (cmd.ptr_load_top) begin
         ptr_in = AW'(count_ff - CW'(1));
      end else if (cmd.ptr_load_pos1) begin
         ptr_in = AW'(pos_ff + CW'(1));
      end else if (cmd.ptr_load_zero) begin
         ptr_in = '0;
      end else if (cmd.rd_en) begin
         ptr_in = (cmd.rd_kind == alie_pkg::RK_UP) ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
      end

      pv_in    = cmd.rd_en;
      pdump_in = (cmd.rd_kind == alie_pkg::RK_DUMP);
      plast_in = stat.ptr_at_end;
      wa_in    = (cmd.rd_kind == alie_pkg::RK_UP) ? ptr_ff + AW'(1) : ptr_ff - AW'(1);

      rsp_strobe_in = cmd.emit | (pv_ff & pdump_ff);
      rsp_count_in  = count_in;
      if (pv_ff && pdump_ff) begin
         rsp_status_in = alie_pkg::ST_OK;
         rsp_has_in    = 1'b1;
         rsp_elem_in   = rdata_ff;
         rsp_last_in   = plast_ff;
      end else begin
         rsp_status_in = cmd.emit_status;
         rsp_has_in    = 1'b0;
         rsp_elem_in   = '0;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pv_ff         <= pv_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      len_ff        <= len_in;
      ptr_ff        <= ptr_in;
      pdump_ff      <= pdump_in;
      plast_ff      <= plast_in;
      wa_ff         <= wa_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Single write port: a moved element or the newly placed value, never both.
   always_ff @(posedge clock) begin
      if (pv_ff && !pdump_ff) begin
         element_store_ff[wa_ff] <= rdata_ff;
      end else if (cmd.put) begin
         element_store_ff[pos_ff[AW-1:0]] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= element_store_ff[ptr_ff];
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_has_element = rsp_has_ff;
   assign rsp_element_out = rsp_elem_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hw/rtl/alie_controller.sv =====
// Controller state machine of the ordered list engine.
`timescale 1ns / 1ps

module alie_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  alie_pkg::stat_type stat,
   output alie_pkg::cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_DECODE    = 9'b000000010,
      S_UP        = 9'b000000100,
      S_UP_LAST   = 9'b000001000,
      S_PUT       = 9'b000010000,
      S_DOWN      = 9'b000100000,
      S_DOWN_LAST = 9'b001000000,
      S_DUMP      = 9'b010000000,
      S_DUMP_LAST = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_kind     = alie_pkg::RK_UP;
      cmd.emit_status = alie_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            if (stat.op_append) begin
               if (stat.full) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = alie_pkg::ST_FULL;
               end else begin
                  cmd.set_pos_count = 1'b1;
                  state_in          = S_PUT;
               end
            end else if (stat.op_insert) begin
               if (stat.pos_gt_count) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = alie_pkg::ST_RANGE;
               end else if (stat.full) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = alie_pkg::ST_FULL;
               end else if (stat.pos_eq_count) begin
                  state_in = S_PUT;
               end else begin
                  cmd.ptr_load_top = 1'b1;
                  state_in         = S_UP;
               end
            end else if (stat.op_remove) begin
               if (stat.pos_ge_count) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = alie_pkg::ST_RANGE;
               end else if (stat.pos_last) begin
                  cmd.cnt_dec = 1'b1;
                  cmd.emit    = 1'b1;
               end else begin
                  cmd.ptr_load_pos1 = 1'b1;
                  state_in          = S_DOWN;
               end
            end else if (stat.op_resize) begin
               cmd.cnt_trunc = 1'b1;
               cmd.emit      = 1'b1;
            end else if (stat.op_dump) begin
               if (stat.empty) begin
                  cmd.emit = 1'b1;
               end else begin
                  cmd.ptr_load_zero = 1'b1;
                  state_in          = S_DUMP;
               end
            end else begin
               cmd.emit = 1'b1;
            end
         end
         S_UP: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_kind = alie_pkg::RK_UP;
            if (stat.ptr_at_pos) begin
               state_in = S_UP_LAST;
            end
         end
         S_UP_LAST: begin
            state_in = S_PUT;
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         S_DOWN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_kind = alie_pkg::RK_DOWN;
            if (stat.ptr_at_end) begin
               state_in = S_DOWN_LAST;
            end
         end
         S_DOWN_LAST: begin
            cmd.cnt_dec = 1'b1;
            cmd.emit    = 1'b1;
            state_in    = S_IDLE;
         end
         S_DUMP: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_kind = alie_pkg::RK_DUMP;
            if (stat.ptr_at_end) begin
               state_in = S_DUMP_LAST;
            end
         end
         S_DUMP_LAST: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/array_list_insert_remove_engine.sv =====
// Top level of the ordered list engine: controller and datapath joined by command and status.
//
//   Channel  | Ports                                        | Handshake
//   ---------+----------------------------------------------+------------------------------------
//   request  | req_operation, req_position, req_new_value,  | taken when start is high and busy
//            | req_new_length                               | is low
//   response | rsp_status, rsp_count_after, rsp_has_element,| one word per cycle with rsp_strobe
//            | rsp_element_out, rsp_last                    | high, no back-pressure
//
// After a request is taken, busy stays high for the decode state plus the walk. Resize,
// unused codes, rejected requests, a remove at the tail and a dump of an empty list end
// in the decode state; an append or an insert at the count goes on to the put state. An
// insert that moves elements shifts those at and above the position up one entry, from the
// top down, then places the value; a remove shifts those after it down one entry; one store
// read per cycle with the write of the moved word overlapped. A dump streams one word per cycle.
// The single-port read and single-port write of the element store set this pace.
// Synchronous active-high reset empties the list at once; store contents are left as they
// are, since only entries below the count are ever read. The receiver cannot stall, and
// every response word is shown for exactly one cycle from a register, dump words after the read pipe.
`timescale 1ns / 1ps

module array_list_insert_remove_engine #(
   parameter int DEPTH = alie_pkg::DEPTH_DEFAULT,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [alie_pkg::OP_W-1:0]         req_operation,
   input  logic [CW-1:0]                     req_position,
   input  logic signed [alie_pkg::VAL_W-1:0] req_new_value,
   input  logic [CW-1:0]                     req_new_length,
   output logic                              rsp_strobe,
   output logic [alie_pkg::STAT_W-1:0]       rsp_status,
   output logic [CW-1:0]                     rsp_count_after,
   output logic                              rsp_has_element,
   output logic signed [alie_pkg::VAL_W-1:0] rsp_element_out,
   output logic                              rsp_last
);

   // Commands flow from the controller to the datapath; flags about the latched request,
   // the count and the walk pointer flow back.
   alie_pkg::cmd_type  cmd;
   alie_pkg::stat_type stat;

   // The controller sequences one request at a time: decode, an optional walk over the
   // store, and the final write or response.
   alie_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath holds the store, the count, the walk pointer, a one-word read pipe
   // and the registered response word.
   alie_datapath #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .req_new_length  (req_new_length),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_count_after (rsp_count_after),
      .rsp_has_element (rsp_has_element),
      .rsp_element_out (rsp_element_out),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== hw/rtl/alie_checker.sv =====
// Port-level checks of the ordered list engine, bound to the top level.
`timescale 1ns / 1ps

module alie_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_strobe,
   input logic [alie_pkg::STAT_W-1:0]       rsp_status,
   input logic                              rsp_has_element,
   input logic signed [alie_pkg::VAL_W-1:0] rsp_element_out,
   input logic                              rsp_last
);

   // A taken request always occupies the engine in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after a request was taken");

   // A dump run streams without gaps until its last word.
   a_dump_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside a dump run");

   // Only dumped elements are unmarked words, and they carry an element.
   a_not_last_has: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> rsp_has_element)
      else $error("non-final word without an element");

   // An error word stands alone and carries no element.
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != alie_pkg::ST_OK) |-> (rsp_last && !rsp_has_element))
      else $error("error status on a dump word");

   // A word without an element shows zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_has_element) |-> (rsp_element_out == '0))
      else $error("element field not zero on a word without an element");

endmodule

bind array_list_insert_remove_engine alie_checker u_alie_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_has_element (rsp_has_element),
   .rsp_element_out (rsp_element_out),
   .rsp_last        (rsp_last)
);
